FILE: rtl/htlp_pkg.sv
// ----------------------------------------------------------------------------
// htlp_pkg
// Shared types and constants for the linear-probing hash table core.
// ----------------------------------------------------------------------------
`default_nettype none

package htlp_pkg;

	localparam int CMD_W    = 2;
	localparam int KEY_W    = 31;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 3;
	localparam int MARK_W   = 2;

	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

	localparam logic [MARK_W-1:0] MARK_EMPTY   = 2'd0;
	localparam logic [MARK_W-1:0] MARK_USED    = 2'd1;
	localparam logic [MARK_W-1:0] MARK_DELETED = 2'd2;

	localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
	localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd5;

	typedef struct packed {
		logic [MARK_W-1:0] mark;
		logic [KEY_W-1:0]  key;
		logic [DATA_W-1:0] value;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

	// The home slot reduction consumes this many key bits per cycle.
	localparam int MOD_DIGIT_W = 4;
	localparam int MOD_STEPS   = (KEY_W + MOD_DIGIT_W - 1) / MOD_DIGIT_W;
	localparam int MOD_PAD_W   = MOD_STEPS * MOD_DIGIT_W;
	localparam int MOD_CNT_W   = $clog2(MOD_STEPS);

endpackage

`default_nettype wire

FILE: rtl/htlp_cmd_if.sv
// ----------------------------------------------------------------------------
// htlp_cmd_if
// Command channel: operation, key and value with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface htlp_cmd_if;
	import htlp_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         command;
	logic [KEY_W-1:0]         key;
	logic signed [DATA_W-1:0] data_in;

	modport source (output valid, output command, output key, output data_in, input ready);
	modport sink   (input valid, input command, input key, input data_in, output ready);
endinterface

`default_nettype wire

FILE: rtl/htlp_rsp_if.sv
// ----------------------------------------------------------------------------
// htlp_rsp_if
// Response channel: status and looked-up value with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface htlp_rsp_if;
	import htlp_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [STATUS_W-1:0]      status;
	logic signed [DATA_W-1:0] data_out;

	modport source (output valid, output status, output data_out, input ready);
	modport sink   (input valid, input status, input data_out, output ready);
endinterface

`default_nettype wire

FILE: rtl/htlp_ram.sv
// ----------------------------------------------------------------------------
// htlp_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module htlp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule

`default_nettype wire

FILE: rtl/htlp_mod.sv
// ----------------------------------------------------------------------------
// htlp_mod
// Iterative reduction of a key modulo the slot count, a few bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module htlp_mod #(
	parameter int MODULUS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [htlp_pkg::KEY_W-1:0]  key,
	output logic                        done,
	output logic [$clog2(MODULUS)-1:0]  rem
);
	import htlp_pkg::*;

	localparam int RW = $clog2(MODULUS);
	localparam logic [RW:0] MOD_VAL = (RW+1)'(MODULUS);
	localparam logic [MOD_CNT_W-1:0] LAST_STEP = MOD_CNT_W'(MOD_STEPS - 1);

	logic                 busy_q;
	logic [MOD_CNT_W-1:0] cnt_q;
	logic [RW-1:0]        rem_q;
	logic [MOD_PAD_W-1:0] sh_q;
	logic [RW:0]          step_v;
	logic [RW-1:0]        rem_next;

	always_comb begin
		rem_next = rem_q;
		step_v   = '0;
		for (int i = 0; i < MOD_DIGIT_W; i++) begin
			step_v = {rem_next, sh_q[MOD_PAD_W-1-i]};
			if (step_v >= MOD_VAL) begin
				step_v = step_v - MOD_VAL;
			end
			rem_next = step_v[RW-1:0];
		end
	end

	assign done = busy_q && (cnt_q == LAST_STEP);
	assign rem  = rem_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			sh_q  <= MOD_PAD_W'(key);
		end else if (busy_q) begin
			rem_q <= rem_next;
			sh_q  <= sh_q << MOD_DIGIT_W;
		end
	end
endmodule

`default_nettype wire

FILE: rtl/hash_table_linear_probe_core.sv
// ----------------------------------------------------------------------------
// hash_table_linear_probe_core
// Key/value table with open addressing, linear probing and tombstones.
// ----------------------------------------------------------------------------
// Each command is accepted only while the core is idle and gives exactly one
// response transaction. From one to TABLE_SLOTS slots are probed for each
// command: the key is reduced to its home slot four bits at a time, the slot
// RAM is then read one slot per cycle through its single read port, and the
// finish state writes any changed slot back and loads the response register
// once the output register is free. The table reads as empty straight after
// reset, as every slot carries a written flag that reset clears; no clearing
// pass is needed. A finished response waits in its output register while the
// next command is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module hash_table_linear_probe_core #(
	parameter int TABLE_SLOTS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	htlp_cmd_if.sink   cmd,
	htlp_rsp_if.source rsp
);
	import htlp_pkg::*;

	localparam int IDX_W = $clog2(TABLE_SLOTS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_HASH   = 4'b0010,
		S_PROBE  = 4'b0100,
		S_FINISH = 4'b1000
	} state_t;

	state_t                   state_q;
	logic [CMD_W-1:0]         cmd_q;
	logic [KEY_W-1:0]         key_q;
	logic [DATA_W-1:0]        din_q;
	logic                     accept;
	logic                     mod_done;
	logic [IDX_W-1:0]         home;
	logic [IDX_W-1:0]         ea_q;
	logic [IDX_W-1:0]         ea_next;
	logic [IDX_W-1:0]         cnt_q;
	logic                     hit_q;
	logic [IDX_W-1:0]         hit_idx_q;
	logic [DATA_W-1:0]        hit_val_q;
	logic                     free_q;
	logic [IDX_W-1:0]         free_idx_q;
	logic [TABLE_SLOTS-1:0]   written_q;
	slot_t                    rd_slot;
	slot_t                    slot_eff;
	slot_t                    wr_slot;
	logic [IDX_W-1:0]         rd_addr;
	logic [IDX_W-1:0]         wr_addr;
	logic                     wr_req;
	logic                     wr_en;
	logic                     key_match;
	logic                     free_cand;
	logic                     probe_end;
	logic                     out_free;
	logic                     rsp_valid_q;
	logic [STATUS_W-1:0]      status_q;
	logic [STATUS_W-1:0]      status_d;
	logic signed [DATA_W-1:0] dout_q;
	logic [DATA_W-1:0]        dout_d;

	assign cmd.ready = (state_q == S_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;

	assign rsp.valid    = rsp_valid_q;
	assign rsp.status   = status_q;
	assign rsp.data_out = dout_q;

	htlp_mod #(
		.MODULUS (TABLE_SLOTS)
	) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.key    (cmd.key),
		.done   (mod_done),
		.rem    (home)
	);

	htlp_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (TABLE_SLOTS)
	) u_slots (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_slot),
		.rd_addr (rd_addr),
		.rd_data (rd_slot)
	);

	assign ea_next = (ea_q == LAST_IDX) ? '0 : ea_q + 1'b1;
	assign rd_addr = (state_q == S_HASH) ? home : ea_next;

	always_comb begin
		slot_eff = rd_slot;
		if (!written_q[ea_q]) begin
			slot_eff.mark = MARK_EMPTY;
		end
	end

	assign key_match = (slot_eff.mark == MARK_USED) && (slot_eff.key == key_q);
	assign free_cand = (slot_eff.mark != MARK_USED);
	assign probe_end = key_match || (slot_eff.mark == MARK_EMPTY) || (cnt_q == LAST_IDX);

	always_comb begin
		wr_req        = 1'b0;
		wr_addr       = hit_idx_q;
		wr_slot.mark  = MARK_USED;
		wr_slot.key   = key_q;
		wr_slot.value = din_q;
		status_d      = ST_NOT_FOUND;
		dout_d        = '0;
		case (cmd_q)
			CMD_INSERT: begin
				if (hit_q) begin
					wr_req   = 1'b1;
					status_d = ST_UPDATED;
				end else if (free_q) begin
					wr_req   = 1'b1;
					wr_addr  = free_idx_q;
					status_d = ST_INSERTED;
				end else begin
					status_d = ST_FULL;
				end
			end
			CMD_SEARCH: begin
				if (hit_q) begin
					status_d = ST_FOUND;
					dout_d   = hit_val_q;
				end
			end
			CMD_REMOVE: begin
				if (hit_q) begin
					wr_req        = 1'b1;
					wr_slot.mark  = MARK_DELETED;
					wr_slot.value = '0;
					status_d      = ST_REMOVED;
				end
			end
			default: begin
			end
		endcase
	end

	assign wr_en = (state_q == S_FINISH) && out_free && wr_req;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			written_q   <= '0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			if ((state_q == S_FINISH) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					if (mod_done) begin
						hit_q   <= 1'b0;
						free_q  <= 1'b0;
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					if (key_match) begin
						hit_q <= 1'b1;
					end
					if (free_cand) begin
						free_q <= 1'b1;
					end
					if (probe_end) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd.command;
			key_q <= cmd.key;
			din_q <= cmd.data_in;
		end
		if ((state_q == S_HASH) && mod_done) begin
			ea_q  <= home;
			cnt_q <= '0;
		end else if (state_q == S_PROBE) begin
			ea_q  <= ea_next;
			cnt_q <= cnt_q + 1'b1;
			if (key_match) begin
				hit_idx_q <= ea_q;
				hit_val_q <= slot_eff.value;
			end
			if (free_cand && !free_q) begin
				free_idx_q <= ea_q;
			end
		end
		if ((state_q == S_FINISH) && out_free) begin
			status_q <= status_d;
			dout_q   <= dout_d;
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !cmd.ready)
		else $error("Command accepted while the previous one was still in progress.");

	a_search_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (cmd_q != CMD_SEARCH))
		else $error("Slot RAM written during a search.");

	a_data_only_found: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status != ST_FOUND)) |-> (rsp.data_out == '0))
		else $error("Non-zero value returned with a status other than found.");

	a_hash_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		mod_done |-> (state_q == S_HASH))
		else $error("Home slot reduction finished outside the hashing phase.");

	a_probe_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_PROBE) && (cnt_q == LAST_IDX)) |=> (state_q == S_FINISH))
		else $error("Probe sequence ran past the last slot.");

endmodule

`default_nettype wire

FILE: tb/sv/htlp_table_checker.sv
// ----------------------------------------------------------------------------
// htlp_table_checker
// Watches the command and response channels of the hash table core, keeps
// its own copy of the slot marks, keys and values, works out the status and
// value due for every accepted command and compares each response transaction
// with the oldest one still due.
// ----------------------------------------------------------------------------

module htlp_table_checker
	import htlp_pkg::*;
#(
	parameter int SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	htlp_cmd_if         cmd,
	htlp_rsp_if         rsp,
	output int unsigned mismatches,
	output int unsigned pending,
	output int unsigned checked,
	output int unsigned hits,
	output int unsigned removals,
	output int unsigned full_reports
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [KEY_W-1:0]    key;
		logic [STATUS_W-1:0] status;
		logic [DATA_W-1:0]   data;
	} table_reply_t;

	logic [MARK_W-1:0] slot_state [SLOTS];
	logic [KEY_W-1:0]  slot_keys  [SLOTS];
	logic [DATA_W-1:0] slot_data  [SLOTS];
	table_reply_t      replies_due [$];

	int unsigned n_err     = 0;
	int unsigned n_checked = 0;
	int unsigned n_hits    = 0;
	int unsigned n_removed = 0;
	int unsigned n_full    = 0;

	function automatic table_reply_t table_apply(input logic [CMD_W-1:0] op,
			input logic [KEY_W-1:0] k, input logic [DATA_W-1:0] v);
		table_reply_t reply;
		int           idx;
		int           hit;
		int           free_at;
		bit           stop;
		reply.key    = k;
		reply.status = ST_NOT_FOUND;
		reply.data   = '0;
		hit          = -1;
		free_at      = -1;
		stop         = 1'b0;
		idx          = int'(k % SLOTS);
		for (int n = 0; n < SLOTS && !stop; n++) begin
			if (slot_state[idx] == MARK_EMPTY) begin
				if (free_at < 0)
					free_at = idx;
				stop = 1'b1;
			end else if (slot_state[idx] == MARK_USED) begin
				if (slot_keys[idx] == k) begin
					hit  = idx;
					stop = 1'b1;
				end
			end else if (free_at < 0) begin
				free_at = idx;
			end
			idx = (idx + 1) % SLOTS;
		end
		case (op)
			CMD_INSERT: begin
				if (hit >= 0) begin
					slot_data[hit] = v;
					reply.status   = ST_UPDATED;
				end else if (free_at >= 0) begin
					slot_state[free_at] = MARK_USED;
					slot_keys[free_at]  = k;
					slot_data[free_at]  = v;
					reply.status        = ST_INSERTED;
				end else begin
					reply.status = ST_FULL;
				end
			end
			CMD_SEARCH: begin
				if (hit >= 0) begin
					reply.status = ST_FOUND;
					reply.data   = slot_data[hit];
				end
			end
			CMD_REMOVE: begin
				if (hit >= 0) begin
					slot_state[hit] = MARK_DELETED;
					slot_data[hit]  = '0;
					reply.status    = ST_REMOVED;
				end
			end
			default: begin
			end
		endcase
		return reply;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		table_reply_t due;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++)
				slot_state[i] = MARK_EMPTY;
			replies_due.delete();
		end else begin
			if (rsp.valid && rsp.ready) begin
				n_checked++;
				if (replies_due.size() == 0) begin
					n_err++;
					$display("%0t: response with nothing due, got status %0d data %0d",
						$time, rsp.status, $signed(rsp.data_out));
				end else begin
					due = replies_due.pop_front();
					if (rsp.status !== due.status) begin
						n_err++;
						$display("%0t: key %0h status expected %0d, got %0d",
							$time, due.key, due.status, rsp.status);
					end
					if (rsp.data_out !== due.data) begin
						n_err++;
						$display("%0t: key %0h data_out expected %0d, got %0d",
							$time, due.key, $signed(due.data), $signed(rsp.data_out));
					end
					if (due.status == ST_FOUND)
						n_hits++;
					if (due.status == ST_REMOVED)
						n_removed++;
					if (due.status == ST_FULL)
						n_full++;
				end
			end
			if (cmd.valid && cmd.ready)
				replies_due.push_back(table_apply(cmd.command, cmd.key, cmd.data_in));
		end
		mismatches   <= n_err;
		pending      <= replies_due.size();
		checked      <= n_checked;
		hits         <= n_hits;
		removals     <= n_removed;
		full_reports <= n_full;
	end

endmodule

FILE: tb/sv/tb_hash_table_linear_probe_core.sv
// ----------------------------------------------------------------------------
// tb_hash_table_linear_probe_core
// Drives insert, search and remove commands into the hash table core: a
// directed opening over collisions, tombstones and wrap-around, then random
// traffic over a small key pool with bursts that fill the table, under three
// handshake regimes and one long response hold-off. A separate checker
// predicts and compares every response transaction.
// ----------------------------------------------------------------------------

module tb_hash_table_linear_probe_core;
	timeunit 1ns;
	timeprecision 1ps;
	import htlp_pkg::*;

	localparam int SLOTS        = 16;
	localparam int POOL_SIZE    = 24;
	localparam int PHASE_ITEMS  = 455;
	localparam int BURST_KEYS   = SLOTS + 4;
	localparam int HOLD_CYCLES  = 400;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 40;
	localparam int MAX_GAP      = 40;

	logic clk;
	logic arst_n;

	htlp_cmd_if cmd_if ();
	htlp_rsp_if rsp_if ();

	int unsigned mismatches;
	int unsigned pending;
	int unsigned checked;
	int unsigned hits;
	int unsigned removals;
	int unsigned full_reports;

	int               send_idle_pct;
	int               drain_idle_pct;
	bit               hold_request;
	int unsigned      issued;
	int               hot_home;
	logic [KEY_W-1:0] key_pool [POOL_SIZE];

	hash_table_linear_probe_core #(
		.TABLE_SLOTS(SLOTS)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_if),
		.rsp   (rsp_if)
	);

	htlp_table_checker #(
		.SLOTS(SLOTS)
	) table_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd_if),
		.rsp         (rsp_if),
		.mismatches  (mismatches),
		.pending     (pending),
		.checked     (checked),
		.hits        (hits),
		.removals    (removals),
		.full_reports(full_reports)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [KEY_W-1:0] fresh_key();
		logic [31:0] r;
		r = $urandom;
		return r[KEY_W-1:0];
	endfunction

	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(7))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			2:       return '0;
			3:       return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [KEY_W-1:0] pool_key();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(3))
			0:       return r[KEY_W-1:0];
			1:       return KEY_W'((r[KEY_W-1:0] / SLOTS) * SLOTS + hot_home);
			2:       return KEY_W'($urandom_range(4 * SLOTS - 1));
			default: return KEY_W'(31'h7fff_ffff - $urandom_range(2 * SLOTS));
		endcase
	endfunction

	task automatic issue(input logic [CMD_W-1:0] op, input logic [KEY_W-1:0] k,
			input logic [DATA_W-1:0] v);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			cmd_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_if.valid   <= 1'b1;
		cmd_if.command <= op;
		cmd_if.key     <= k;
		cmd_if.data_in <= v;
		@(posedge clk);
		while (!cmd_if.ready)
			@(posedge clk);
		issued++;
	endtask

	task automatic fill_burst(output int count);
		logic [KEY_W-1:0] burst_keys [BURST_KEYS];
		for (int i = 0; i < BURST_KEYS; i++) begin
			burst_keys[i] = fresh_key();
			issue(CMD_INSERT, burst_keys[i], pick_value());
		end
		repeat (4) issue(CMD_SEARCH, fresh_key(), pick_value());
		for (int i = BURST_KEYS - 1; i >= 0; i--)
			issue(CMD_REMOVE, burst_keys[i], pick_value());
		count = 2 * BURST_KEYS + 4;
	endtask

	task automatic run_phase(input bit opening_burst);
		int               done;
		int               roll;
		int               burst_items;
		logic [CMD_W-1:0] op;
		logic [KEY_W-1:0] k;
		hot_home = $urandom_range(SLOTS - 1);
		foreach (key_pool[i])
			key_pool[i] = pool_key();
		done = 0;
		if (opening_burst) begin
			fill_burst(burst_items);
			done += burst_items;
		end
		while (done < PHASE_ITEMS) begin
			if ($urandom_range(99) == 0) begin
				fill_burst(burst_items);
				done += burst_items;
			end else begin
				roll = $urandom_range(99);
				if (roll < 40)
					op = CMD_INSERT;
				else if (roll < 75)
					op = CMD_SEARCH;
				else
					op = CMD_REMOVE;
				if (op != CMD_INSERT && $urandom_range(9) == 0)
					k = fresh_key();
				else
					k = key_pool[$urandom_range(POOL_SIZE - 1)];
				issue(op, k, pick_value());
				done++;
			end
		end
		foreach (key_pool[i])
			issue(CMD_REMOVE, key_pool[i], pick_value());
	endtask

	initial begin : response_drain
		int held;
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				rsp_if.ready <= 1'b0;
				for (held = 1; held < HOLD_CYCLES; held++)
					@(posedge clk);
			end else begin
				rsp_if.ready <= ($urandom_range(99) >= drain_idle_pct);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
		$display("Test completed with failures");
		$finish;
	end

	initial begin : stimulus
		arst_n         <= 1'b0;
		cmd_if.valid   <= 1'b0;
		cmd_if.command <= CMD_SEARCH;
		cmd_if.key     <= '0;
		cmd_if.data_in <= '0;
		send_idle_pct  = 27;
		drain_idle_pct = 73;
		hold_request   = 1'b0;
		issued         = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(CMD_SEARCH, KEY_W'(5), 32'h1234_5678);
		issue(CMD_REMOVE, KEY_W'(5), '0);
		issue(CMD_INSERT, KEY_W'(0), 32'h8000_0000);
		issue(CMD_INSERT, KEY_W'(SLOTS), 32'h7fff_ffff);
		issue(CMD_INSERT, KEY_W'(2 * SLOTS), '1);
		issue(CMD_SEARCH, KEY_W'(SLOTS), '0);
		issue(CMD_INSERT, KEY_W'(0), '0);
		issue(CMD_REMOVE, KEY_W'(0), '1);
		issue(CMD_SEARCH, KEY_W'(2 * SLOTS), '0);
		issue(CMD_INSERT, KEY_W'(2 * SLOTS), 32'd7);
		issue(CMD_INSERT, KEY_W'(3 * SLOTS), -32'sd2);
		issue(CMD_SEARCH, KEY_W'(0), '0);
		issue(CMD_INSERT, 31'h7fff_ffff, 32'd1);
		issue(CMD_INSERT, KEY_W'(31'h7fff_ffff - SLOTS), 32'd2);
		issue(CMD_SEARCH, KEY_W'(31'h7fff_ffff - SLOTS), '0);
		issue(CMD_REMOVE, 31'h7fff_ffff, '0);
		issue(CMD_REMOVE, 31'h7fff_ffff, '0);

		run_phase(1'b1);
		send_idle_pct  = 73;
		drain_idle_pct = 27;
		run_phase(1'b0);
		send_idle_pct  = 0;
		drain_idle_pct = 0;
		hold_request   = 1'b1;
		run_phase(1'b0);

		cmd_if.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d commands: directed probing cases, table-fill bursts and three",
			issued);
		$display("handshake regimes with a %0d-cycle hold-off; %0d responses checked (%0d hits, %0d removals, %0d table full, %0d mismatches).",
			HOLD_CYCLES, checked, hits, removals, full_reports, mismatches);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
